>>> sv/vntg_pkg.sv
// ----------------------------------------------------------------------------
// vntg_pkg
// Shared types, constants and fixed-point helpers for the vertex normal and
// tangent generator.
// ----------------------------------------------------------------------------
package vntg_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int VERT_AW      = $clog2(MAX_VERTICES);
  localparam int ACC_W        = 21;
  localparam int Q_ONE        = 16384;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_TRI  = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } opcode_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_EDGE,
    ST_FIT,
    ST_CR_MUL,
    ST_CR_ACC,
    ST_NN_GO,
    ST_NN_WAIT,
    ST_NACC_RD,
    ST_NACC_WR,
    ST_DET_MUL,
    ST_DET_ACC,
    ST_TFIT,
    ST_TG_MUL,
    ST_TG_ACC,
    ST_TN_GO,
    ST_TN_WAIT,
    ST_TACC_RD,
    ST_TACC_WR,
    ST_RV_RD,
    ST_RV_LAT,
    ST_RVN_GO,
    ST_RVN_WAIT,
    ST_RVT_GO,
    ST_RVT_WAIT,
    ST_OUT
  } seq_state_t;

  typedef enum logic [3:0] {
    NS_IDLE,
    NS_SHIFT,
    NS_SQ,
    NS_SUM,
    NS_CHK,
    NS_SQRT,
    NS_DLOAD,
    NS_DIV,
    NS_DONE
  } norm_state_t;

  function automatic logic signed [32:0] diff33(input logic [31:0] a, input logic [31:0] b);
    return $signed({a[31], a}) - $signed({b[31], b});
  endfunction

  function automatic logic [32:0] mag33(input logic signed [32:0] x);
    return x[32] ? 33'(-x) : 33'(x);
  endfunction

  // smallest right shift that brings every magnitude below 2^30
  function automatic logic [1:0] fit_shift(input logic [32:0] m_or);
    logic [1:0] s;
    if (m_or[32]) s = 2'd3;
    else if (m_or[31]) s = 2'd2;
    else if (m_or[30]) s = 2'd1;
    else s = 2'd0;
    return s;
  endfunction

  function automatic logic signed [32:0] scale_down(input logic signed [32:0] x,
                                                    input logic [1:0] s);
    logic [32:0] m;
    m = mag33(x) >> s;
    return x[32] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [20:0] sat_add(input logic signed [20:0] a,
                                                 input logic signed [15:0] u);
    logic signed [21:0] t;
    t = 22'(a) + 22'(u);
    if (t > 22'sd1048575) t = 22'sd1048575;
    else if (t < -22'sd1048576) t = -22'sd1048576;
    return t[20:0];
  endfunction

  function automatic logic [62:0] acc_add3(input logic [62:0] acc,
                                           input logic signed [15:0] u0,
                                           input logic signed [15:0] u1,
                                           input logic signed [15:0] u2);
    return {sat_add(acc[62:42], u2), sat_add(acc[41:21], u1), sat_add(acc[20:0], u0)};
  endfunction

  function automatic logic signed [63:0] sx21(input logic [20:0] x);
    return 64'($signed(x));
  endfunction

endpackage

>>> sv/vntg_ram.sv
// ----------------------------------------------------------------------------
// vntg_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module vntg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> sv/vntg_norm.sv
// ----------------------------------------------------------------------------
// vntg_norm
// Iterative vector normalizer: common shift, sum of squares, bitwise square
// root and restoring division to Q1.14 unit components.
// ----------------------------------------------------------------------------
module vntg_norm (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] v0,
  input  logic signed [63:0] v1,
  input  logic signed [63:0] v2,
  output logic               done,
  output logic signed [15:0] u0,
  output logic signed [15:0] u1,
  output logic signed [15:0] u2
);

  vntg_pkg::norm_state_t state, state_next;

  logic [63:0]        m [0:2];
  logic [2:0]         neg;
  logic [1:0]         k;
  logic [59:0]        sq_prod;
  logic [63:0]        sum;
  logic [63:0]        sn, sr, sbit;
  logic [63:0]        st;
  logic [46:0]        dn, dd;
  logic [14:0]        q, q_new, q_cap;
  logic [3:0]         cnt;
  logic               ge;
  logic [63:0]        m_or;
  logic signed [15:0] u [0:2];

  assign m_or  = m[0] | m[1] | m[2];
  assign st    = sr + sbit;
  assign ge    = dn >= dd;
  assign q_new = {q[13:0], ge};
  assign q_cap = (q_new > 15'(vntg_pkg::Q_ONE)) ? 15'(vntg_pkg::Q_ONE) : q_new;
  assign done  = (state == vntg_pkg::NS_DONE);
  assign u0    = u[0];
  assign u1    = u[1];
  assign u2    = u[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vntg_pkg::NS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      vntg_pkg::NS_IDLE:  if (start) state_next = vntg_pkg::NS_SHIFT;
      vntg_pkg::NS_SHIFT: if (!(|m_or[63:30])) state_next = vntg_pkg::NS_SQ;
      vntg_pkg::NS_SQ:    state_next = vntg_pkg::NS_SUM;
      vntg_pkg::NS_SUM:   state_next = (k == 2'd2) ? vntg_pkg::NS_CHK : vntg_pkg::NS_SQ;
      vntg_pkg::NS_CHK:   state_next = (sum == 64'd0) ? vntg_pkg::NS_DONE : vntg_pkg::NS_SQRT;
      vntg_pkg::NS_SQRT:  if (sbit[0]) state_next = vntg_pkg::NS_DLOAD;
      vntg_pkg::NS_DLOAD: state_next = vntg_pkg::NS_DIV;
      vntg_pkg::NS_DIV: begin
        if (cnt == 4'd14) begin
          state_next = (k == 2'd2) ? vntg_pkg::NS_DONE : vntg_pkg::NS_DLOAD;
        end
      end
      vntg_pkg::NS_DONE:  state_next = vntg_pkg::NS_IDLE;
      default:            state_next = vntg_pkg::NS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      vntg_pkg::NS_IDLE: begin
        if (start) begin
          m[0] <= v0[63] ? 64'(-v0) : 64'(v0);
          m[1] <= v1[63] ? 64'(-v1) : 64'(v1);
          m[2] <= v2[63] ? 64'(-v2) : 64'(v2);
          neg  <= {v2[63], v1[63], v0[63]};
        end
      end
      vntg_pkg::NS_SHIFT: begin
        if (|m_or[63:34]) begin
          for (int i = 0; i < 3; i++) m[i] <= m[i] >> 4;
        end else if (|m_or[63:30]) begin
          for (int i = 0; i < 3; i++) m[i] <= m[i] >> 1;
        end else begin
          k   <= 2'd0;
          sum <= 64'd0;
        end
      end
      vntg_pkg::NS_SQ: begin
        sq_prod <= m[k][29:0] * m[k][29:0];
      end
      vntg_pkg::NS_SUM: begin
        sum <= sum + 64'(sq_prod);
        if (k != 2'd2) k <= k + 2'd1;
      end
      vntg_pkg::NS_CHK: begin
        if (sum == 64'd0) begin
          for (int i = 0; i < 3; i++) u[i] <= 16'sd0;
        end
        sn   <= sum;
        sr   <= 64'd0;
        sbit <= 64'd1 << 62;
        k    <= 2'd0;
      end
      vntg_pkg::NS_SQRT: begin
        if (sn >= st) begin
          sn <= sn - st;
          sr <= (sr >> 1) + sbit;
        end else begin
          sr <= sr >> 1;
        end
        sbit <= sbit >> 2;
      end
      vntg_pkg::NS_DLOAD: begin
        dn  <= {2'b0, m[k][29:0], 15'b0} + 47'(sr[31:0]);
        dd  <= {sr[31:0], 15'b0};
        q   <= 15'd0;
        cnt <= 4'd0;
      end
      vntg_pkg::NS_DIV: begin
        if (ge) dn <= dn - dd;
        dd  <= dd >> 1;
        q   <= q_new;
        cnt <= cnt + 4'd1;
        if (cnt == 4'd14) begin
          u[k] <= neg[k] ? -$signed(16'(q_cap)) : $signed(16'(q_cap));
          k    <= k + 2'd1;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> sv/vertex_normal_tangent_gen.sv
// ----------------------------------------------------------------------------
// vertex_normal_tangent_gen
// Per-vertex normal and tangent generation over a 1024-slot vertex store,
// sequenced around one shared 33x33 multiplier and an iterative normalizer.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid / in_stall  opcode, pos_*, tex_*, given_n*, vert_a/b/c
//  out      out_valid/ out_stall out_n*, out_t*, index_error
//  cfg      cfg_valid/ cfg_ready cfg_data (compute_normals)
//
// a load is written straight from the idle state; reads and triangles are paced
// by the normalizer (32-step square root, 15-step divide per axis) and by the
// multiply/accumulate steps of the shared multiplier; a triangle is shorter
// without normals or with flat uv.
// rst is synchronous; memories are not cleared. in_stall is high while an
// item is in work; a finished read waits in the output register under stall.
// ----------------------------------------------------------------------------
module vertex_normal_tangent_gen (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] tex_u,
  input  logic signed [31:0] tex_v,
  input  logic signed [15:0] given_nx,
  input  logic signed [15:0] given_ny,
  input  logic signed [15:0] given_nz,
  input  logic [9:0]         vert_a,
  input  logic [9:0]         vert_b,
  input  logic [9:0]         vert_c,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_nx,
  output logic signed [15:0] out_ny,
  output logic signed [15:0] out_nz,
  output logic signed [15:0] out_tx,
  output logic signed [15:0] out_ty,
  output logic signed [15:0] out_tz,
  output logic               index_error,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);

  localparam int AW = vntg_pkg::VERT_AW;

  vntg_pkg::seq_state_t state, state_next;

  logic compute_normals;
  logic bad_index_seen;

  logic [AW-1:0] ia, ib, ic, idx;
  logic          rd_bad;
  logic [1:0]    cc;
  logic [2:0]    ms;

  logic [AW-1:0] rd_addr, wr_addr;
  logic          pos_we, tex_we, nacc_we, tacc_we;
  logic [95:0]   pos_rdata;
  logic [63:0]   tex_rdata;
  logic [62:0]   nacc_rdata, tacc_rdata, nacc_wdata, tacc_wdata;

  logic [95:0]        p0, p1, p2;
  logic [63:0]        t0, t1, t2;
  logic signed [32:0] ed [0:5];
  logic signed [32:0] ta, tb, tc, td;
  logic [32:0]        e_or;
  logic [1:0]         s_e, s_t;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod, pad;
  logic               det_neg;
  logic signed [63:0] vec [0:2];
  logic signed [63:0] w_diff;
  logic [62:0]        tsave;

  logic               norm_start, norm_done;
  logic signed [15:0] nu0, nu1, nu2;
  logic signed [15:0] onx, ony, onz;

  logic in_fire, bad_a, bad_tri;
  logic [62:0] load_n;

  assign in_stall  = (state != vntg_pkg::ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign bad_a     = ({1'b0, vert_a} >= 11'(vntg_pkg::MAX_VERTICES));
  assign bad_tri   = bad_a || ({1'b0, vert_b} >= 11'(vntg_pkg::MAX_VERTICES))
                           || ({1'b0, vert_c} >= 11'(vntg_pkg::MAX_VERTICES));
  assign load_n    = compute_normals ? 63'd0
                   : {21'(given_nz), 21'(given_ny), 21'(given_nx)};
  assign idx       = (cc == 2'd0) ? ia : ((cc == 2'd1) ? ib : ic);

  always_comb begin
    e_or = 33'd0;
    for (int i = 0; i < 6; i++) e_or = e_or | vntg_pkg::mag33(ed[i]);
  end
  assign s_e    = vntg_pkg::fit_shift(e_or);
  assign s_t    = vntg_pkg::fit_shift(vntg_pkg::mag33(tb) | vntg_pkg::mag33(td));
  assign w_diff = vec[ms[2:1]] - $signed(prod[63:0]);

  vntg_ram #(.WIDTH(96), .DEPTH(vntg_pkg::MAX_VERTICES)) u_pos (
    .clk, .we(pos_we), .waddr(wr_addr), .wdata({pos_z, pos_y, pos_x}),
    .raddr(rd_addr), .rdata(pos_rdata)
  );

  vntg_ram #(.WIDTH(64), .DEPTH(vntg_pkg::MAX_VERTICES)) u_tex (
    .clk, .we(tex_we), .waddr(wr_addr), .wdata({tex_v, tex_u}),
    .raddr(rd_addr), .rdata(tex_rdata)
  );

  vntg_ram #(.WIDTH(63), .DEPTH(vntg_pkg::MAX_VERTICES)) u_nacc (
    .clk, .we(nacc_we), .waddr(wr_addr), .wdata(nacc_wdata),
    .raddr(rd_addr), .rdata(nacc_rdata)
  );

  vntg_ram #(.WIDTH(63), .DEPTH(vntg_pkg::MAX_VERTICES)) u_tacc (
    .clk, .we(tacc_we), .waddr(wr_addr), .wdata(tacc_wdata),
    .raddr(rd_addr), .rdata(tacc_rdata)
  );

  vntg_norm u_norm (
    .clk, .rst, .start(norm_start),
    .v0(vec[0]), .v1(vec[1]), .v2(vec[2]),
    .done(norm_done), .u0(nu0), .u1(nu1), .u2(nu2)
  );

  // shared multiplier operand select
  always_comb begin
    mul_a = ta;
    mul_b = td;
    case (state)
      vntg_pkg::ST_CR_MUL: begin
        case (ms)
          3'd0:    begin mul_a = ed[1]; mul_b = ed[5]; end
          3'd1:    begin mul_a = ed[2]; mul_b = ed[4]; end
          3'd2:    begin mul_a = ed[2]; mul_b = ed[3]; end
          3'd3:    begin mul_a = ed[0]; mul_b = ed[5]; end
          3'd4:    begin mul_a = ed[0]; mul_b = ed[4]; end
          default: begin mul_a = ed[1]; mul_b = ed[3]; end
        endcase
      end
      vntg_pkg::ST_DET_MUL: begin
        mul_a = ms[0] ? tb : ta;
        mul_b = ms[0] ? tc : td;
      end
      vntg_pkg::ST_TG_MUL: begin
        mul_a = ms[0] ? tb : td;
        case (ms[2:1])
          2'd0:    mul_b = ms[0] ? ed[3] : ed[0];
          2'd1:    mul_b = ms[0] ? ed[4] : ed[1];
          default: mul_b = ms[0] ? ed[5] : ed[2];
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= vntg_pkg::ST_IDLE;
      compute_normals <= 1'b1;
      bad_index_seen  <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) compute_normals <= cfg_data;
      if (in_fire && vntg_pkg::opcode_t'(opcode) == vntg_pkg::OP_TRI && bad_tri) begin
        bad_index_seen <= 1'b1;
      end
      if (state == vntg_pkg::ST_OUT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    rd_addr    = ia;
    wr_addr    = idx;
    pos_we     = 1'b0;
    tex_we     = 1'b0;
    nacc_we    = 1'b0;
    tacc_we    = 1'b0;
    nacc_wdata = vntg_pkg::acc_add3(nacc_rdata, nu0, nu1, nu2);
    tacc_wdata = vntg_pkg::acc_add3(tacc_rdata, nu0, nu1, nu2);
    norm_start = 1'b0;
    unique case (state)
      vntg_pkg::ST_IDLE: begin
        wr_addr    = vert_a;
        nacc_wdata = load_n;
        tacc_wdata = 63'd0;
        if (in_fire) begin
          unique case (vntg_pkg::opcode_t'(opcode))
            vntg_pkg::OP_LOAD: begin
              if (!bad_a) begin
                pos_we  = 1'b1;
                tex_we  = 1'b1;
                nacc_we = 1'b1;
                tacc_we = 1'b1;
              end
            end
            vntg_pkg::OP_TRI:  if (!bad_tri) state_next = vntg_pkg::ST_RD0;
            vntg_pkg::OP_READ: state_next = bad_a ? vntg_pkg::ST_OUT : vntg_pkg::ST_RV_RD;
            default: ;
          endcase
        end
      end
      vntg_pkg::ST_RD0: begin rd_addr = ia; state_next = vntg_pkg::ST_RD1; end
      vntg_pkg::ST_RD1: begin rd_addr = ib; state_next = vntg_pkg::ST_RD2; end
      vntg_pkg::ST_RD2: begin rd_addr = ic; state_next = vntg_pkg::ST_RD3; end
      vntg_pkg::ST_RD3: state_next = vntg_pkg::ST_EDGE;
      vntg_pkg::ST_EDGE: state_next = vntg_pkg::ST_FIT;
      vntg_pkg::ST_FIT: begin
        state_next = compute_normals ? vntg_pkg::ST_CR_MUL : vntg_pkg::ST_DET_MUL;
      end
      vntg_pkg::ST_CR_MUL: state_next = vntg_pkg::ST_CR_ACC;
      vntg_pkg::ST_CR_ACC: begin
        state_next = (ms == 3'd5) ? vntg_pkg::ST_NN_GO : vntg_pkg::ST_CR_MUL;
      end
      vntg_pkg::ST_NN_GO: begin norm_start = 1'b1; state_next = vntg_pkg::ST_NN_WAIT; end
      vntg_pkg::ST_NN_WAIT: if (norm_done) state_next = vntg_pkg::ST_NACC_RD;
      vntg_pkg::ST_NACC_RD: begin rd_addr = idx; state_next = vntg_pkg::ST_NACC_WR; end
      vntg_pkg::ST_NACC_WR: begin
        nacc_we    = 1'b1;
        state_next = (cc == 2'd2) ? vntg_pkg::ST_DET_MUL : vntg_pkg::ST_NACC_RD;
      end
      vntg_pkg::ST_DET_MUL: state_next = vntg_pkg::ST_DET_ACC;
      vntg_pkg::ST_DET_ACC: begin
        if (ms == 3'd0) state_next = vntg_pkg::ST_DET_MUL;
        else state_next = (pad == prod) ? vntg_pkg::ST_IDLE : vntg_pkg::ST_TFIT;
      end
      vntg_pkg::ST_TFIT: state_next = vntg_pkg::ST_TG_MUL;
      vntg_pkg::ST_TG_MUL: state_next = vntg_pkg::ST_TG_ACC;
      vntg_pkg::ST_TG_ACC: begin
        state_next = (ms == 3'd5) ? vntg_pkg::ST_TN_GO : vntg_pkg::ST_TG_MUL;
      end
      vntg_pkg::ST_TN_GO: begin norm_start = 1'b1; state_next = vntg_pkg::ST_TN_WAIT; end
      vntg_pkg::ST_TN_WAIT: if (norm_done) state_next = vntg_pkg::ST_TACC_RD;
      vntg_pkg::ST_TACC_RD: begin rd_addr = idx; state_next = vntg_pkg::ST_TACC_WR; end
      vntg_pkg::ST_TACC_WR: begin
        tacc_we    = 1'b1;
        state_next = (cc == 2'd2) ? vntg_pkg::ST_IDLE : vntg_pkg::ST_TACC_RD;
      end
      vntg_pkg::ST_RV_RD: begin rd_addr = ia; state_next = vntg_pkg::ST_RV_LAT; end
      vntg_pkg::ST_RV_LAT: state_next = vntg_pkg::ST_RVN_GO;
      vntg_pkg::ST_RVN_GO: begin norm_start = 1'b1; state_next = vntg_pkg::ST_RVN_WAIT; end
      vntg_pkg::ST_RVN_WAIT: if (norm_done) state_next = vntg_pkg::ST_RVT_GO;
      vntg_pkg::ST_RVT_GO: begin norm_start = 1'b1; state_next = vntg_pkg::ST_RVT_WAIT; end
      vntg_pkg::ST_RVT_WAIT: if (norm_done) state_next = vntg_pkg::ST_OUT;
      vntg_pkg::ST_OUT: if (!out_valid || !out_stall) state_next = vntg_pkg::ST_IDLE;
      default: state_next = vntg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      vntg_pkg::ST_IDLE: begin
        if (in_fire) begin
          ia     <= vert_a;
          ib     <= vert_b;
          ic     <= vert_c;
          rd_bad <= bad_a;
        end
      end
      vntg_pkg::ST_RD1: begin p0 <= pos_rdata; t0 <= tex_rdata; end
      vntg_pkg::ST_RD2: begin p1 <= pos_rdata; t1 <= tex_rdata; end
      vntg_pkg::ST_RD3: begin p2 <= pos_rdata; t2 <= tex_rdata; end
      vntg_pkg::ST_EDGE: begin
        ed[0] <= vntg_pkg::diff33(p1[31:0],  p0[31:0]);
        ed[1] <= vntg_pkg::diff33(p1[63:32], p0[63:32]);
        ed[2] <= vntg_pkg::diff33(p1[95:64], p0[95:64]);
        ed[3] <= vntg_pkg::diff33(p2[31:0],  p0[31:0]);
        ed[4] <= vntg_pkg::diff33(p2[63:32], p0[63:32]);
        ed[5] <= vntg_pkg::diff33(p2[95:64], p0[95:64]);
        ta    <= vntg_pkg::diff33(t1[31:0],  t0[31:0]);
        tb    <= vntg_pkg::diff33(t1[63:32], t0[63:32]);
        tc    <= vntg_pkg::diff33(t2[31:0],  t0[31:0]);
        td    <= vntg_pkg::diff33(t2[63:32], t0[63:32]);
      end
      vntg_pkg::ST_FIT: begin
        for (int i = 0; i < 6; i++) ed[i] <= vntg_pkg::scale_down(ed[i], s_e);
        ms <= 3'd0;
      end
      vntg_pkg::ST_CR_MUL, vntg_pkg::ST_DET_MUL, vntg_pkg::ST_TG_MUL: begin
        prod <= mul_a * mul_b;
      end
      vntg_pkg::ST_CR_ACC: begin
        vec[ms[2:1]] <= ms[0] ? w_diff : $signed(prod[63:0]);
        ms <= (ms == 3'd5) ? 3'd0 : ms + 3'd1;
      end
      vntg_pkg::ST_NN_GO, vntg_pkg::ST_TN_GO: cc <= 2'd0;
      vntg_pkg::ST_NACC_WR, vntg_pkg::ST_TACC_WR: cc <= cc + 2'd1;
      vntg_pkg::ST_DET_ACC: begin
        if (ms == 3'd0) begin
          pad <= prod;
          ms  <= 3'd1;
        end else begin
          det_neg <= pad < prod;
          ms      <= 3'd0;
        end
      end
      vntg_pkg::ST_TFIT: begin
        tb <= vntg_pkg::scale_down(tb, s_t);
        td <= vntg_pkg::scale_down(td, s_t);
      end
      vntg_pkg::ST_TG_ACC: begin
        if (ms[0]) vec[ms[2:1]] <= det_neg ? -w_diff : w_diff;
        else vec[ms[2:1]] <= $signed(prod[63:0]);
        ms <= (ms == 3'd5) ? 3'd0 : ms + 3'd1;
      end
      vntg_pkg::ST_RV_LAT: begin
        vec[0] <= vntg_pkg::sx21(nacc_rdata[20:0]);
        vec[1] <= vntg_pkg::sx21(nacc_rdata[41:21]);
        vec[2] <= vntg_pkg::sx21(nacc_rdata[62:42]);
        tsave  <= tacc_rdata;
      end
      vntg_pkg::ST_RVN_WAIT: begin
        if (norm_done) begin
          onx    <= nu0;
          ony    <= nu1;
          onz    <= nu2;
          vec[0] <= vntg_pkg::sx21(tsave[20:0]);
          vec[1] <= vntg_pkg::sx21(tsave[41:21]);
          vec[2] <= vntg_pkg::sx21(tsave[62:42]);
        end
      end
      vntg_pkg::ST_OUT: begin
        if (!out_valid || !out_stall) begin
          out_nx      <= rd_bad ? 16'sd0 : onx;
          out_ny      <= rd_bad ? 16'sd0 : ony;
          out_nz      <= rd_bad ? 16'sd0 : onz;
          out_tx      <= rd_bad ? 16'sd0 : nu0;
          out_ty      <= rd_bad ? 16'sd0 : nu1;
          out_tz      <= rd_bad ? 16'sd0 : nu2;
          index_error <= bad_index_seen;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> sim/vntg_checker.sv
// ----------------------------------------------------------------------------
// vntg_checker
// Watches the input, output and register channels of the vertex normal and
// tangent generator, keeps its own copy of the vertex store and accumulators,
// predicts every read transaction and compares it field by field.
// ----------------------------------------------------------------------------
module vntg_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] tex_u,
  input  logic signed [31:0] tex_v,
  input  logic signed [15:0] given_nx,
  input  logic signed [15:0] given_ny,
  input  logic signed [15:0] given_nz,
  input  logic [9:0]         vert_a,
  input  logic [9:0]         vert_b,
  input  logic [9:0]         vert_c,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] out_nx,
  input  logic signed [15:0] out_ny,
  input  logic signed [15:0] out_nz,
  input  logic signed [15:0] out_tx,
  input  logic signed [15:0] out_ty,
  input  logic signed [15:0] out_tz,
  input  logic               index_error,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_data,
  output int                 failures,
  output int                 pending
);

  typedef struct packed {
    logic signed [15:0] nx, ny, nz, tx, ty, tz;
    logic               err;
  } vertex_result_t;

  localparam longint unsigned FIT_LIM = 64'd1 << 30;

  int             vx [vntg_pkg::MAX_VERTICES], vy [vntg_pkg::MAX_VERTICES];
  int             vz [vntg_pkg::MAX_VERTICES];
  int             vu [vntg_pkg::MAX_VERTICES], vv [vntg_pkg::MAX_VERTICES];
  int             nacc [vntg_pkg::MAX_VERTICES][3];
  int             tacc [vntg_pkg::MAX_VERTICES][3];
  logic           bad_seen;
  logic           gen_normals;
  vertex_result_t expected_reads [$];

  assign pending = expected_reads.size();

  function automatic longint unsigned magn(longint x);
    return x < 0 ? longint'(-x) : x;
  endfunction

  function automatic int fit(longint unsigned m);
    int s;
    s = 0;
    while ((m >> s) >= FIT_LIM) s++;
    return s;
  endfunction

  function automatic longint shrink(longint x, int s);
    longint r;
    r = longint'(magn(x) >> s);
    return x < 0 ? -r : r;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic void unit_vec(input longint v [3], output int u [3]);
    longint unsigned m [3];
    longint unsigned mx, sum, len, q;
    int s;
    mx = 0;
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      m[k] = magn(v[k]);
      if (m[k] > mx) mx = m[k];
    end
    s = fit(mx);
    for (int k = 0; k < 3; k++) begin
      m[k] >>= s;
      sum += m[k] * m[k];
    end
    for (int k = 0; k < 3; k++) u[k] = 0;
    if (sum == 0) return;
    len = floor_sqrt(sum);
    for (int k = 0; k < 3; k++) begin
      q = (m[k] * 2 * vntg_pkg::Q_ONE + len) / (2 * len);
      if (q > vntg_pkg::Q_ONE) q = vntg_pkg::Q_ONE;
      u[k] = v[k] < 0 ? -int'(q) : int'(q);
    end
  endfunction

  function automatic int sat_acc(int a, int b);
    int t;
    t = a + b;
    if (t > 1048575) return 1048575;
    if (t < -1048576) return -1048576;
    return t;
  endfunction

  function automatic void add_triangle(int i0, int i1, int i2);
    longint e0 [3], e1 [3], w [3], nv [3];
    longint a, b, c, d;
    logic signed [127:0] pa, pb, pc, pd, det;
    longint unsigned mx;
    int u [3];
    int s;
    e0[0] = longint'(vx[i1]) - vx[i0];
    e0[1] = longint'(vy[i1]) - vy[i0];
    e0[2] = longint'(vz[i1]) - vz[i0];
    e1[0] = longint'(vx[i2]) - vx[i0];
    e1[1] = longint'(vy[i2]) - vy[i0];
    e1[2] = longint'(vz[i2]) - vz[i0];
    mx = 0;
    for (int k = 0; k < 3; k++) begin
      if (magn(e0[k]) > mx) mx = magn(e0[k]);
      if (magn(e1[k]) > mx) mx = magn(e1[k]);
    end
    s = fit(mx);
    for (int k = 0; k < 3; k++) begin
      e0[k] = shrink(e0[k], s);
      e1[k] = shrink(e1[k], s);
    end
    if (gen_normals) begin
      nv[0] = e0[1] * e1[2] - e0[2] * e1[1];
      nv[1] = e0[2] * e1[0] - e0[0] * e1[2];
      nv[2] = e0[0] * e1[1] - e0[1] * e1[0];
      unit_vec(nv, u);
      for (int k = 0; k < 3; k++) begin
        nacc[i0][k] = sat_acc(nacc[i0][k], u[k]);
        nacc[i1][k] = sat_acc(nacc[i1][k], u[k]);
        nacc[i2][k] = sat_acc(nacc[i2][k], u[k]);
      end
    end
    a = longint'(vu[i1]) - vu[i0];
    b = longint'(vv[i1]) - vv[i0];
    c = longint'(vu[i2]) - vu[i0];
    d = longint'(vv[i2]) - vv[i0];
    pa = a;
    pb = b;
    pc = c;
    pd = d;
    det = pa * pd - pb * pc;
    if (det == 0) return;
    mx = magn(b) > magn(d) ? magn(b) : magn(d);
    s = fit(mx);
    b = shrink(b, s);
    d = shrink(d, s);
    for (int k = 0; k < 3; k++) begin
      w[k] = d * e0[k] - b * e1[k];
      if (det < 0) w[k] = -w[k];
    end
    unit_vec(w, u);
    for (int k = 0; k < 3; k++) begin
      tacc[i0][k] = sat_acc(tacc[i0][k], u[k]);
      tacc[i1][k] = sat_acc(tacc[i1][k], u[k]);
      tacc[i2][k] = sat_acc(tacc[i2][k], u[k]);
    end
  endfunction

  function automatic vertex_result_t read_vertex(int i);
    vertex_result_t r;
    longint v [3];
    int n [3], t [3];
    for (int k = 0; k < 3; k++) v[k] = nacc[i][k];
    unit_vec(v, n);
    for (int k = 0; k < 3; k++) v[k] = tacc[i][k];
    unit_vec(v, t);
    r.nx = n[0];
    r.ny = n[1];
    r.nz = n[2];
    r.tx = t[0];
    r.ty = t[1];
    r.tz = t[2];
    r.err = bad_seen;
    return r;
  endfunction

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    vertex_result_t e;
    if (rst) begin
      bad_seen = 1'b0;
      gen_normals = 1'b1;
      expected_reads.delete();
      for (int i = 0; i < vntg_pkg::MAX_VERTICES; i++) begin
        vx[i] = 0; vy[i] = 0; vz[i] = 0; vu[i] = 0; vv[i] = 0;
        for (int k = 0; k < 3; k++) begin
          nacc[i][k] = 0;
          tacc[i][k] = 0;
        end
      end
    end else begin
      if (cfg_valid && cfg_ready) gen_normals = cfg_data;
      if (in_valid && !in_stall) begin
        case (opcode)
          vntg_pkg::OP_LOAD: begin
            vx[vert_a] = pos_x;
            vy[vert_a] = pos_y;
            vz[vert_a] = pos_z;
            vu[vert_a] = tex_u;
            vv[vert_a] = tex_v;
            nacc[vert_a][0] = gen_normals ? 0 : int'(given_nx);
            nacc[vert_a][1] = gen_normals ? 0 : int'(given_ny);
            nacc[vert_a][2] = gen_normals ? 0 : int'(given_nz);
            for (int k = 0; k < 3; k++) tacc[vert_a][k] = 0;
          end
          vntg_pkg::OP_TRI:  add_triangle(vert_a, vert_b, vert_c);
          vntg_pkg::OP_READ: expected_reads = {expected_reads, read_vertex(vert_a)};
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_reads.size() == 0) begin
          $error("read transaction with no expectation waiting");
          failures++;
        end else begin
          e = expected_reads.pop_front();
          check_field("out_nx", e.nx, out_nx);
          check_field("out_ny", e.ny, out_ny);
          check_field("out_nz", e.nz, out_nz);
          check_field("out_tx", e.tx, out_tx);
          check_field("out_ty", e.ty, out_ty);
          check_field("out_tz", e.tz, out_tz);
          check_field("index_error", e.err, index_error);
        end
      end
    end
  end

  initial failures = 0;

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives vertex loads, triangles and reads into the vertex normal and tangent
// generator over several idle/stall phases and both normal modes; the
// checker beside the block predicts and compares each read transaction.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct {
    vntg_pkg::opcode_t  op;
    logic signed [31:0] px, py, pz, u, v;
    logic signed [15:0] nx, ny, nz;
    logic [9:0]         a, b, c;
  } vertex_op_t;

  localparam int WATCHDOG_LIMIT = 20000;

  logic               clk, rst;
  logic               in_valid, in_stall;
  logic [1:0]         opcode;
  logic signed [31:0] pos_x, pos_y, pos_z, tex_u, tex_v;
  logic signed [15:0] given_nx, given_ny, given_nz;
  logic [9:0]         vert_a, vert_b, vert_c;
  logic               out_valid, out_stall;
  logic signed [15:0] out_nx, out_ny, out_nz, out_tx, out_ty, out_tz;
  logic               index_error;
  logic               cfg_valid, cfg_ready, cfg_data;
  int                 failures, pending;
  int                 send_idle_pct, recv_stall_pct, hold_cycles, quiet_cycles;
  logic [9:0]         loaded_slots [$];

  vertex_normal_tangent_gen i_dut (.*);

  vntg_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= $urandom_range(99) < recv_stall_pct;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
        || rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[vertex_normal_tangent_gen] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic offer(vertex_op_t t);
    opcode   <= t.op;
    pos_x    <= t.px;
    pos_y    <= t.py;
    pos_z    <= t.pz;
    tex_u    <= t.u;
    tex_v    <= t.v;
    given_nx <= t.nx;
    given_ny <= t.ny;
    given_nz <= t.nz;
    vert_a   <= t.a;
    vert_b   <= t.b;
    vert_c   <= t.c;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (t.op == vntg_pkg::OP_LOAD) loaded_slots = {loaded_slots, t.a};
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic set_mode(logic val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [31:0] any_coord();
    case ($urandom_range(9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 0;
      3, 4: return $urandom;
      default: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
    endcase
  endfunction

  function automatic logic signed [15:0] any_normal();
    return 16'($signed(17'($urandom_range(0, 32768))) - 17'sd16384);
  endfunction

  function automatic vertex_op_t load_op(logic [9:0] slot);
    vertex_op_t t;
    t.op = vntg_pkg::OP_LOAD;
    t.px = any_coord();
    t.py = any_coord();
    t.pz = any_coord();
    t.u = any_coord();
    t.v = any_coord();
    t.nx = any_normal();
    t.ny = any_normal();
    t.nz = any_normal();
    t.a = slot;
    t.b = 10'($urandom);
    t.c = 10'($urandom);
    return t;
  endfunction

  function automatic logic [9:0] recent_slot();
    int n;
    n = loaded_slots.size();
    if ($urandom_range(3) == 0) return loaded_slots[$urandom_range(n - 1)];
    return loaded_slots[n - 1 - $urandom_range(n > 6 ? 5 : n - 1)];
  endfunction

  function automatic vertex_op_t tri_op(logic [9:0] a, logic [9:0] b, logic [9:0] c);
    vertex_op_t t;
    t = load_op(a);
    t.op = vntg_pkg::OP_TRI;
    t.b = b;
    t.c = c;
    return t;
  endfunction

  function automatic vertex_op_t read_op(logic [9:0] a);
    vertex_op_t t;
    t = tri_op(a, 10'($urandom), 10'($urandom));
    t.op = vntg_pkg::OP_READ;
    return t;
  endfunction

  task automatic random_phase(int count);
    vertex_op_t t;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        offer(load_op($urandom_range(2) == 0 ? recent_slot() : 10'($urandom)));
      end else if (pick < 65) begin
        offer(tri_op(recent_slot(), recent_slot(), recent_slot()));
      end else if (pick < 95) begin
        offer(read_op(recent_slot()));
      end else begin
        t = load_op(10'($urandom));
        t.op = vntg_pkg::OP_NONE;
        offer(t);
      end
    end
  endtask

  initial begin
    vertex_op_t t;
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = vntg_pkg::OP_NONE;
    {pos_x, pos_y, pos_z, tex_u, tex_v} = '0;
    {given_nx, given_ny, given_nz, vert_a, vert_b, vert_c} = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    quiet_cycles = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, repeated corners, flat uv, collinear edges
    t = load_op(0);
    t.px = 32'sh7fff_ffff; t.py = 32'sh8000_0000; t.pz = 0;
    t.u = 32'sh8000_0000; t.v = 32'sh7fff_ffff;
    offer(t);
    t = load_op(1023);
    t.px = 32'sh8000_0000; t.py = 32'sh7fff_ffff; t.pz = 32'sh7fff_ffff;
    t.u = 32'sh7fff_ffff; t.v = 32'sh8000_0000;
    offer(t);
    t = load_op(1);
    t.px = 32'sh0001_0000; t.py = 0; t.pz = 0; t.u = 32'sh0001_0000; t.v = 0;
    offer(t);
    t = load_op(2);
    t.px = 0; t.py = 32'sh0001_0000; t.pz = 0; t.u = 0; t.v = 32'sh0001_0000;
    offer(t);
    t = load_op(3);
    t.px = 32'sh0002_0000; t.py = 0; t.pz = 0; t.u = 32'sh0002_0000; t.v = 0;
    offer(t);
    offer(read_op(0));
    offer(tri_op(0, 1023, 1));
    offer(tri_op(0, 1, 2));
    offer(tri_op(1, 1, 2));
    offer(tri_op(0, 1, 3));
    offer(tri_op(2, 2, 2));
    t = load_op(5);
    t.op = vntg_pkg::OP_NONE;
    offer(t);
    offer(read_op(0));
    offer(read_op(1));
    offer(read_op(2));
    offer(read_op(3));
    offer(read_op(1023));

    // long hold-off on the result side while reads keep coming
    hold_cycles <= 3000;
    for (int i = 0; i < 4; i++) offer(read_op(10'(i)));
    random_phase(90);

    set_mode(1'b0);
    send_idle_pct = 77;
    t = load_op(7);
    t.nx = 16'sd16384; t.ny = -16'sd16384; t.nz = 0;
    offer(t);
    t = load_op(8);
    t.nx = 0; t.ny = 0; t.nz = 0;
    offer(t);
    offer(read_op(7));
    offer(read_op(8));
    random_phase(90);

    set_mode(1'b1);
    send_idle_pct = 0;
    recv_stall_pct = 77;
    // saturate the accumulators of three corners
    offer(load_op(100));
    offer(load_op(101));
    offer(load_op(102));
    for (int i = 0; i < 70; i++) offer(tri_op(100, 101, 102));
    offer(read_op(100));
    offer(read_op(102));
    random_phase(60);

    set_mode(1'b0);
    send_idle_pct = 34;
    recv_stall_pct = 34;
    random_phase(100);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (failures == 0) begin
      $display("[vertex_normal_tangent_gen] OK");
    end else begin
      $display("[vertex_normal_tangent_gen] ERROR");
    end
    $finish;
  end

endmodule
